// File: rtl/fcqd_pkg.sv
// ----------------------------------------------------------------------------
// fcqd_pkg
// Shared types and constants of the flow class queue dispatcher.
// ----------------------------------------------------------------------------
package fcqd_pkg;

    localparam int NUM_PORTS   = 8;
    localparam int COUNT_WIDTH = 10;
    localparam int PORT_IDX_W  = (NUM_PORTS > 1) ? $clog2(NUM_PORTS) : 1;

    // Field widths of the channel words and of the configuration registers.
    localparam int OP_W      = 1;
    localparam int LIDX_W    = 3;
    localparam int LCNT_W    = 10;
    localparam int CIDX_W    = 3;
    localparam int COCC_W    = 10;
    localparam int MASK_W    = 8;
    localparam int THR_W     = 10;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 10;

    // Width that holds both a counter and the threshold for comparison.
    localparam int CMP_W = (COUNT_WIDTH > THR_W) ? COUNT_WIDTH : THR_W;

    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

    localparam logic [OP_W-1:0] OP_DISPATCH = 1'b0;
    localparam logic [OP_W-1:0] OP_LOAD     = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SHORT_MASK = 2'd0,
        REG_LONG_MASK  = 2'd1,
        REG_SHORT_THR  = 2'd2
    } t_reg_idx;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_UPDATE,
        ST_DONE
    } t_state;

endpackage

// File: rtl/fcqd_if.sv
// ----------------------------------------------------------------------------
// fcqd_if
// Valid/ready channels that carry the input word and the result word.
// ----------------------------------------------------------------------------
interface fcqd_in_if import fcqd_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [OP_W-1:0]   operation;
    logic              is_short;
    logic [LIDX_W-1:0] load_index;
    logic [LCNT_W-1:0] load_count;

    modport source (output valid, output operation, output is_short,
                    output load_index, output load_count, input ready);
    modport sink   (input valid, input operation, input is_short,
                    input load_index, input load_count, output ready);
endinterface

interface fcqd_out_if import fcqd_pkg::*; ();
    logic              valid;
    logic              ready;
    logic              found;
    logic [CIDX_W-1:0] chosen_index;
    logic [COCC_W-1:0] chosen_occupancy;

    modport source (output valid, output found, output chosen_index,
                    output chosen_occupancy, input ready);
    modport sink   (input valid, input found, input chosen_index,
                    input chosen_occupancy, output ready);
endinterface

// File: rtl/flow_class_queue_dispatcher_top.sv
// ----------------------------------------------------------------------------
// flow_class_queue_dispatcher_top
// Occupancy-based queue selection for short and long flows.
// ----------------------------------------------------------------------------
// One word is handled at a time. A dispatch word passes through a scan
// state and then an update state before its result is valid. A single
// comparator walks the occupancy counters at one queue per cycle, and the
// update state writes back the incremented counter. A load word writes its
// counter at acceptance, and its result is valid in the next cycle. The result
// is held until it is taken. The next word is accepted in the cycle after
// that.
module flow_class_queue_dispatcher_top
    import fcqd_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    fcqd_in_if.sink               i_in,
    fcqd_out_if.source            o_out,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_state r_state, n_state;

    logic [MASK_W-1:0]      r_short_mask;
    logic [MASK_W-1:0]      r_long_mask;
    logic [THR_W-1:0]       r_thr;
    logic [COUNT_WIDTH-1:0] r_occ [NUM_PORTS];

    logic [PORT_IDX_W-1:0]  r_scan;
    logic                   r_is_short;
    logic                   r_have;
    logic [PORT_IDX_W-1:0]  r_best;
    logic [COUNT_WIDTH-1:0] r_best_occ;

    logic                   in_acc;
    logic                   out_acc;
    logic                   scan_last;
    logic [COUNT_WIDTH-1:0] cur_occ;
    logic                   capable;
    logic                   below_thr;
    logic                   better;
    logic                   take;
    logic [PORT_IDX_W-1:0]  load_idx;
    logic                   load_ok;

    assign in_acc    = i_in.valid && i_in.ready;
    assign out_acc   = o_out.valid && o_out.ready;
    assign scan_last = (r_scan == PORT_IDX_W'(NUM_PORTS - 1));
    assign load_idx  = PORT_IDX_W'(i_in.load_index);
    assign load_ok   = (32'(i_in.load_index) < 32'(NUM_PORTS));

    // The shared compare unit: one counter per cycle against the best so far.
    assign cur_occ   = r_occ[r_scan];
    assign capable   = r_is_short ? |(r_short_mask & (MASK_W'(1) << r_scan))
                                  : |(r_long_mask & (MASK_W'(1) << r_scan));
    assign below_thr = (CMP_W'(cur_occ) < CMP_W'(r_thr));
    assign better    = r_is_short ? (cur_occ < r_best_occ) : (cur_occ > r_best_occ);
    assign take      = capable && (!r_is_short || below_thr) && (!r_have || better);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    n_state = (i_in.operation == OP_LOAD) ? ST_DONE : ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (scan_last) begin
                    n_state = ST_UPDATE;
                end
            end
            ST_UPDATE: begin
                n_state = ST_DONE;
            end
            ST_DONE: begin
                if (out_acc) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        i_in.ready             = (r_state == ST_IDLE);
        o_out.valid            = (r_state == ST_DONE);
        o_out.found            = r_have;
        o_out.chosen_index     = CIDX_W'(r_best);
        o_out.chosen_occupancy = COCC_W'(r_best_occ);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_short_mask <= '1;
            r_long_mask  <= '1;
            r_thr        <= THR_W'(16);
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_SHORT_MASK: r_short_mask <= MASK_W'(i_cfg_data);
                REG_LONG_MASK:  r_long_mask  <= MASK_W'(i_cfg_data);
                REG_SHORT_THR:  r_thr        <= THR_W'(i_cfg_data);
                default: begin
                end
            endcase
        end
    end

    // A load word and the write-back of a dispatch never overlap in time.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_PORTS; i++) begin
                r_occ[i] <= '0;
            end
        end else if (in_acc && i_in.operation == OP_LOAD && load_ok) begin
            r_occ[load_idx] <= COUNT_WIDTH'(i_in.load_count);
        end else if (r_state == ST_UPDATE && r_have && r_best_occ != COUNT_MAX) begin
            r_occ[r_best] <= r_best_occ + COUNT_WIDTH'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scan     <= '0;
            r_have     <= 1'b0;
            r_is_short <= 1'b0;
            r_best     <= '0;
            r_best_occ <= '0;
        end else if (in_acc) begin
            r_scan     <= '0;
            r_have     <= 1'b0;
            r_is_short <= i_in.is_short;
            r_best     <= '0;
            r_best_occ <= '0;
        end else if (r_state == ST_SCAN) begin
            r_scan <= scan_last ? '0 : r_scan + PORT_IDX_W'(1);
            if (take) begin
                r_have     <= 1'b1;
                r_best     <= r_scan;
                r_best_occ <= cur_occ;
            end
        end
    end

    // A word is never taken in while a result is on offer.
    a_ready_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> !i_in.ready)
        else $error("input ready while a result is pending");

    // Every scan starts at the first queue.
    a_scan_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_state == ST_SCAN) |-> (r_scan == '0))
        else $error("scan did not start at queue zero");

    // A result without a chosen queue carries zero index and occupancy.
    a_none_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && !o_out.found) |->
            (o_out.chosen_index == '0 && o_out.chosen_occupancy == '0))
        else $error("result without a queue has nonzero payload");

    // The chosen counter advances by one unless it is already at its maximum.
    a_incr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_UPDATE && r_have && r_best_occ != COUNT_MAX) |=>
            (r_occ[r_best] == $past(r_best_occ) + COUNT_WIDTH'(1)))
        else $error("chosen counter not incremented");

endmodule
